/* design/prq_pkg.sv */
// Shared types and codes for the priority ready queue.
`timescale 1ns / 1ps

package prq_pkg;

  localparam int ID_W  = 6;
  localparam int CMD_W = 2;
  localparam int ST_W  = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic apply;
  } ctl_t;

endpackage

/* design/prq_ctrl.sv */
// Controller state machine for the priority ready queue.
`timescale 1ns / 1ps

module prq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output prq_pkg::ctl_t ctl
);

  typedef enum logic {
    IDLE,
    APPLY
  } state_t;

  state_t state;

  assign ctl.capture = start && !busy;
  assign ctl.apply   = (state == APPLY);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= APPLY;
            busy  <= 1'b1;
          end
        end
        APPLY: begin
          state <= IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
        end
        default: begin
          state <= IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* design/prq_datapath.sv */
// Cell chain holding the ordered queue, with compare, scan and shift logic.
`timescale 1ns / 1ps

module prq_datapath #(
  parameter int QUEUE_DEPTH   = 64,
  parameter int PRIORITY_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  prq_pkg::ctl_t                      ctl,
  input  logic [prq_pkg::CMD_W-1:0]          cmd,
  input  logic [prq_pkg::ID_W-1:0]           task_id,
  input  logic signed [PRIORITY_BITS-1:0]    task_priority,
  output logic [prq_pkg::ID_W-1:0]           out_id,
  output logic signed [PRIORITY_BITS-1:0]    out_priority,
  output logic [prq_pkg::ST_W-1:0]           result_status,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   occupancy
);

  localparam int CW     = $clog2(QUEUE_DEPTH + 1);
  localparam int LEVELS = $clog2(QUEUE_DEPTH);
  localparam int IW     = prq_pkg::ID_W;
  localparam int PW     = PRIORITY_BITS;

  // Queue cells, head at index 0
  logic [IW-1:0]        ids  [QUEUE_DEPTH];
  logic signed [PW-1:0] pris [QUEUE_DEPTH];
  logic [CW-1:0]        count;

  // Captured command and per-cell compare results
  logic [prq_pkg::CMD_W-1:0] cmd_q;
  logic [IW-1:0]             id_q;
  logic signed [PW-1:0]      pri_q;
  logic [QUEUE_DEPTH-1:0]    ge_q;
  logic [QUEUE_DEPTH-1:0]    hit_q;

  logic [IW-1:0]        ids_next  [QUEUE_DEPTH];
  logic signed [PW-1:0] pris_next [QUEUE_DEPTH];
  logic [CW-1:0]        count_next;
  logic [IW-1:0]        res_id_next;
  logic signed [PW-1:0] res_pri_next;
  logic [prq_pkg::ST_W-1:0] res_st_next;

  // Parallel prefix scan: hit seen at or before each cell, and the
  // priority of the first hit.
  logic [QUEUE_DEPTH-1:0] scan_hit [LEVELS+1];
  logic signed [PW-1:0]   scan_val [LEVELS+1][QUEUE_DEPTH];

  logic full;
  logic empty;
  logic found;

  assign full  = (count == CW'(QUEUE_DEPTH));
  assign empty = (count == '0);

  always_comb begin
    scan_hit[0] = hit_q;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      scan_val[0][i] = hit_q[i] ? pris[i] : '0;
    end
    for (int lv = 0; lv < LEVELS; lv++) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (i >= (1 << lv)) begin
          scan_hit[lv+1][i] = scan_hit[lv][i] | scan_hit[lv][i-(1<<lv)];
          scan_val[lv+1][i] = scan_hit[lv][i-(1<<lv)] ? scan_val[lv][i-(1<<lv)]
                                                      : scan_val[lv][i];
        end else begin
          scan_hit[lv+1][i] = scan_hit[lv][i];
          scan_val[lv+1][i] = scan_val[lv][i];
        end
      end
    end
  end

  assign found = scan_hit[LEVELS][QUEUE_DEPTH-1];

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ids_next[i]  = ids[i];
      pris_next[i] = pris[i];
    end
    count_next   = count;
    res_id_next  = '0;
    res_pri_next = '0;
    res_st_next  = prq_pkg::ST_OK;
    case (cmd_q)
      prq_pkg::CMD_INSERT: begin
        if (full) begin
          res_st_next = prq_pkg::ST_FULL;
        end else begin
          // ge_q is a prefix of the valid cells; the new entry lands just after it
          for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (!ge_q[i]) begin
              if (i == 0) begin
                ids_next[i]  = id_q;
                pris_next[i] = pri_q;
              end else if (ge_q[i-1]) begin
                ids_next[i]  = id_q;
                pris_next[i] = pri_q;
              end else begin
                ids_next[i]  = ids[i-1];
                pris_next[i] = pris[i-1];
              end
            end
          end
          count_next = count + 1'b1;
        end
      end
      prq_pkg::CMD_REMOVE: begin
        if (found) begin
          for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            if (scan_hit[LEVELS][i]) begin
              ids_next[i]  = ids[i+1];
              pris_next[i] = pris[i+1];
            end
          end
          res_id_next  = id_q;
          res_pri_next = scan_val[LEVELS][QUEUE_DEPTH-1];
          count_next   = count - 1'b1;
        end else begin
          res_st_next = prq_pkg::ST_NOT_FOUND;
        end
      end
      prq_pkg::CMD_POP: begin
        if (empty) begin
          res_st_next = prq_pkg::ST_EMPTY;
        end else begin
          for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            ids_next[i]  = ids[i+1];
            pris_next[i] = pris[i+1];
          end
          res_id_next  = ids[0];
          res_pri_next = pris[0];
          count_next   = count - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q <= cmd;
      id_q  <= task_id;
      pri_q <= task_priority;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        ge_q[i]  <= (CW'(i) < count) && (pris[i] >= task_priority);
        hit_q[i] <= (CW'(i) < count) && (ids[i] == task_id);
      end
    end
    if (ctl.apply) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        ids[i]  <= ids_next[i];
        pris[i] <= pris_next[i];
      end
      out_id        <= res_id_next;
      out_priority  <= res_pri_next;
      result_status <= res_st_next;
      occupancy     <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.apply) begin
      count <= count_next;
    end
  end

endmodule

/* design/priority_ready_queue.sv */
// Top level of the priority ready queue: controller and cell-chain datapath.
//
// Usage:
//   A command (cmd, task_id, task_priority) is transferred at a rising edge
//   with start high and busy low. Insert places the task behind all entries
//   of greater or equal priority; remove takes out the named task nearest
//   the head; pop takes the head.
//   Each command gives one result (out_id, out_priority, result_status,
//   occupancy), shown for exactly one cycle with done high; the command is
//   captured at the transfer and the result is registered at the end of APPLY.
//   busy is high in the cycle after the transfer, so a new command is taken
//   only once the previous one has been applied.
//   The cell chain compares every cell against the command at the capture,
//   then in the APPLY state scans the compare vector and shifts the
//   cells in parallel.
//   The receiver cannot stall; done is a plain strobe.
//   Reset (rst, synchronous) empties the queue at once; no clearing pass.
//   Occupancy counts the tasks held after the command.
`timescale 1ns / 1ps

module priority_ready_queue #(
  parameter int QUEUE_DEPTH   = 64,
  parameter int PRIORITY_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [prq_pkg::CMD_W-1:0]        cmd,
  input  logic [prq_pkg::ID_W-1:0]         task_id,
  input  logic signed [PRIORITY_BITS-1:0]  task_priority,
  output logic                             done,
  output logic [prq_pkg::ID_W-1:0]         out_id,
  output logic signed [PRIORITY_BITS-1:0]  out_priority,
  output logic [prq_pkg::ST_W-1:0]         result_status,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] occupancy
);

  prq_pkg::ctl_t ctl;

  prq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  prq_datapath #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .cmd           (cmd),
    .task_id       (task_id),
    .task_priority (task_priority),
    .out_id        (out_id),
    .out_priority  (out_priority),
    .result_status (result_status),
    .occupancy     (occupancy)
  );

endmodule

/* tb/priority_ready_queue_tb.sv */
// Self-checking testbench for the priority ready queue: directed table, then random load.
`timescale 1ns / 1ps

module priority_ready_queue_tb;

  localparam int DEPTH = 64;
  localparam int PBITS = 16;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS = 1330;
  localparam int NUM_DIRECTED = 26;
  // Spare command code: the block must leave the queue alone.
  localparam logic [prq_pkg::CMD_W-1:0] CMD_NOP = 2'd3;

  typedef enum int {FILL_UP, DRAIN_DOWN, MIXED} load_mode_t;

  typedef struct packed {
    logic [prq_pkg::ID_W-1:0] id;
    logic [PBITS-1:0]         pri;
    logic [prq_pkg::ST_W-1:0] status;
    logic [OCC_W-1:0]         occ;
  } result_t;

  typedef struct packed {
    logic [prq_pkg::CMD_W-1:0] cmd;
    logic [prq_pkg::ID_W-1:0]  id;
    logic [PBITS-1:0]          pri;
    logic                      typed;
    result_t                   want;
  } row_t;

  localparam result_t NO_WANT = '0;

  // Rows marked typed carry their expected result; the rest use the predictor.
  localparam row_t DIRECTED [NUM_DIRECTED] = '{
    '{prq_pkg::CMD_POP, 6'd0, 16'h0000, 1'b1, '{6'd0, 16'h0000, prq_pkg::ST_EMPTY, 7'd0}},
    '{prq_pkg::CMD_REMOVE, 6'd5, 16'h0000, 1'b1, '{6'd0, 16'h0000, prq_pkg::ST_NOT_FOUND, 7'd0}},
    '{CMD_NOP, 6'd63, 16'hFFFF, 1'b1, '{6'd0, 16'h0000, prq_pkg::ST_OK, 7'd0}},
    '{prq_pkg::CMD_INSERT, 6'd0, 16'h8000, 1'b1, '{6'd0, 16'h0000, prq_pkg::ST_OK, 7'd1}},
    '{prq_pkg::CMD_INSERT, 6'd63, 16'h7FFF, 1'b1, '{6'd0, 16'h0000, prq_pkg::ST_OK, 7'd2}},
    '{prq_pkg::CMD_INSERT, 6'd10, 16'h0000, 1'b0, NO_WANT},
    '{prq_pkg::CMD_INSERT, 6'd11, 16'h0000, 1'b0, NO_WANT},
    '{prq_pkg::CMD_INSERT, 6'd12, 16'h0000, 1'b0, NO_WANT},
    '{prq_pkg::CMD_INSERT, 6'd10, 16'h0000, 1'b0, NO_WANT},
    '{prq_pkg::CMD_POP, 6'd0, 16'h0000, 1'b1, '{6'd63, 16'h7FFF, prq_pkg::ST_OK, 7'd5}},
    '{prq_pkg::CMD_REMOVE, 6'd10, 16'h0000, 1'b0, NO_WANT},
    '{prq_pkg::CMD_POP,    6'd0,  16'h0000, 1'b0, NO_WANT},
    '{prq_pkg::CMD_INSERT, 6'd20, 16'hFFFF, 1'b0, NO_WANT},
    '{prq_pkg::CMD_INSERT, 6'd21, 16'h0001, 1'b0, NO_WANT},
    '{prq_pkg::CMD_REMOVE, 6'd0,  16'h0000, 1'b0, NO_WANT},
    '{prq_pkg::CMD_REMOVE, 6'd63, 16'h0000, 1'b0, NO_WANT},
    '{prq_pkg::CMD_INSERT, 6'd42, 16'h5555, 1'b0, NO_WANT},
    '{prq_pkg::CMD_INSERT, 6'd21, 16'hAAAA, 1'b0, NO_WANT},
    '{CMD_NOP,             6'd0,  16'h0000, 1'b0, NO_WANT},
    '{prq_pkg::CMD_REMOVE, 6'd21, 16'h0000, 1'b0, NO_WANT},
    '{prq_pkg::CMD_POP,    6'd0,  16'h0000, 1'b0, NO_WANT},
    '{prq_pkg::CMD_POP,    6'd0,  16'h0000, 1'b0, NO_WANT},
    '{prq_pkg::CMD_POP,    6'd0,  16'h0000, 1'b0, NO_WANT},
    '{prq_pkg::CMD_POP,    6'd0,  16'h0000, 1'b0, NO_WANT},
    '{prq_pkg::CMD_POP,    6'd0,  16'h0000, 1'b0, NO_WANT},
    '{prq_pkg::CMD_POP, 6'd0, 16'h0000, 1'b1, '{6'd0, 16'h0000, prq_pkg::ST_EMPTY, 7'd0}}
  };

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic [prq_pkg::CMD_W-1:0] cmd;
  logic [prq_pkg::ID_W-1:0]  task_id;
  logic signed [PBITS-1:0]   task_priority;
  logic                      done;
  logic [prq_pkg::ID_W-1:0]  out_id;
  logic signed [PBITS-1:0]   out_priority;
  logic [prq_pkg::ST_W-1:0]  result_status;
  logic [OCC_W-1:0]          occupancy;

  // Typed expectation travelling with the command on the bus.
  logic    row_typed;
  result_t row_want;

  // Predicted queue contents, head first.
  logic [prq_pkg::ID_W-1:0] held_ids[$];
  logic signed [PBITS-1:0]  held_pris[$];
  result_t                  pending_results[$];
  int                       errors = 0;

  priority_ready_queue #(
    .QUEUE_DEPTH  (DEPTH),
    .PRIORITY_BITS(PBITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .task_id      (task_id),
    .task_priority(task_priority),
    .done         (done),
    .out_id       (out_id),
    .out_priority (out_priority),
    .result_status(result_status),
    .occupancy    (occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t apply_command(logic [prq_pkg::CMD_W-1:0] c,
                                            logic [prq_pkg::ID_W-1:0] id,
                                            logic signed [PBITS-1:0] pri);
    result_t r;
    int      pos;
    r = '0;
    r.status = prq_pkg::ST_OK;
    case (c)
      prq_pkg::CMD_INSERT: begin
        if (held_ids.size() >= DEPTH) begin
          r.status = prq_pkg::ST_FULL;
        end else begin
          // goes behind every entry of equal or higher priority
          pos = 0;
          while (pos < held_ids.size() && held_pris[pos] >= pri) pos++;
          held_ids.insert(pos, id);
          held_pris.insert(pos, pri);
        end
      end
      prq_pkg::CMD_REMOVE: begin
        pos = 0;
        while (pos < held_ids.size() && held_ids[pos] != id) pos++;
        if (pos < held_ids.size()) begin
          r.id  = held_ids[pos];
          r.pri = held_pris[pos];
          held_ids.delete(pos);
          held_pris.delete(pos);
        end else begin
          r.status = prq_pkg::ST_NOT_FOUND;
        end
      end
      prq_pkg::CMD_POP: begin
        if (held_ids.size() == 0) begin
          r.status = prq_pkg::ST_EMPTY;
        end else begin
          r.id  = held_ids.pop_front();
          r.pri = held_pris.pop_front();
        end
      end
      default: ;
    endcase
    r.occ = OCC_W'(held_ids.size());
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t predicted;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: id %0d status %0d occupancy %0d",
                 out_id, result_status, occupancy);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_id !== want.id) begin
            $error("out_id: expected %0d, got %0d", want.id, out_id);
            errors++;
          end
          if (out_priority !== want.pri) begin
            $error("out_priority: expected %0d, got %0d", $signed(want.pri), out_priority);
            errors++;
          end
          if (result_status !== want.status) begin
            $error("result_status: expected %0d, got %0d", want.status, result_status);
            errors++;
          end
          if (occupancy !== want.occ) begin
            $error("occupancy: expected %0d, got %0d", want.occ, occupancy);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        predicted = apply_command(cmd, task_id, task_priority);
        pending_results.push_back(row_typed ? row_want : predicted);
      end
    end
  end

  // Holds the command until the block takes it; start stays high for a following command.
  task automatic send_command(logic [prq_pkg::CMD_W-1:0] c, logic [prq_pkg::ID_W-1:0] id,
                              logic [PBITS-1:0] pri, logic typed, result_t want);
    @(negedge clk);
    cmd           = c;
    task_id       = id;
    task_priority = pri;
    row_typed     = typed;
    row_want      = want;
    start         = 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(int cycles);
    @(negedge clk);
    start = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic send_random(load_mode_t mode);
    int                        roll;
    int                        insert_pct;
    logic [31:0]               rnd;
    logic [prq_pkg::CMD_W-1:0] c;
    logic [prq_pkg::ID_W-1:0]  id;
    logic [PBITS-1:0]          pri;
    case (mode)
      FILL_UP:    insert_pct = 85;
      DRAIN_DOWN: insert_pct = 15;
      default:    insert_pct = 45;
    endcase
    roll = $urandom_range(99);
    if (roll < 2) c = CMD_NOP;
    else if (roll < insert_pct) c = prq_pkg::CMD_INSERT;
    else if (roll < insert_pct + (100 - insert_pct) / 2) c = prq_pkg::CMD_REMOVE;
    else c = prq_pkg::CMD_POP;

    // removes mostly name a task that is actually queued
    if (c == prq_pkg::CMD_REMOVE && held_ids.size() > 0 && $urandom_range(3) != 0) begin
      id = held_ids[$urandom_range(held_ids.size() - 1)];
    end else begin
      rnd = $urandom;
      id  = rnd[prq_pkg::ID_W-1:0];
    end

    roll = $urandom_range(9);
    if (roll < 3) begin
      rnd = $urandom_range(4) - 2;  // narrow band, plenty of ties
      pri = rnd[PBITS-1:0];
    end else if (roll == 3) begin
      case ($urandom_range(3))
        0:       pri = 16'h8000;
        1:       pri = 16'h7FFF;
        2:       pri = 16'hFFFF;
        default: pri = 16'h0000;
      endcase
    end else begin
      rnd = $urandom;
      pri = rnd[PBITS-1:0];
    end
    send_command(c, id, pri, 1'b0, NO_WANT);
  endtask

  initial begin
    load_mode_t mode;
    rst           = 1'b1;
    start         = 1'b0;
    cmd           = prq_pkg::CMD_INSERT;
    task_id       = '0;
    task_priority = '0;
    row_typed     = 1'b0;
    row_want      = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_command(DIRECTED[i].cmd, DIRECTED[i].id, DIRECTED[i].pri,
                   DIRECTED[i].typed, DIRECTED[i].want);

    // fill to the brim, drain to empty, then churn; repeated
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 260 < 100) mode = FILL_UP;
      else if (n % 260 < 200) mode = DRAIN_DOWN;
      else mode = MIXED;
      if ((n < 500 || n >= 800) && $urandom_range(99) < 11)
        hold_off($urandom_range(1, 4));
      send_random(mode);
    end
    @(negedge clk);
    start = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("priority_ready_queue_tb: clean");
    end else begin
      $display("priority_ready_queue_tb: errors");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("priority_ready_queue_tb: errors");
    $finish;
  end

endmodule

/* sim.f */
design/prq_pkg.sv
design/prq_ctrl.sv
design/prq_datapath.sv
design/priority_ready_queue.sv
tb/priority_ready_queue_tb.sv
